// ----- rtl/ulist_pkg.sv -----
`default_nettype none

package ulist_pkg;

  // Operation codes carried by the operation field.
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_FIND   = 2'd1,
    OP_ADD    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_EVAL,
    S_OUT
  } state_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic probe;      // capture compare and read tap this cycle
    logic live;       // cell holds a valid entry
    logic sel;        // cell sits at the requested position
    logic load;       // write the incoming identifier
    logic take_next;  // copy the right-hand neighbour's entry
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/unique_id_list_table_unit.sv -----
// Channel | Direction | Handshake          | Payload
// in      | into      | in_valid, in_stall  | operation, item_id, position
// out     | out of    | out_valid, out_stall | ok, result_value, entry_count
//
// An item passes from the transfer in to the first cycle its result is offered
// through a transfer cycle, a probe cycle in which every cell compares and taps its
// entry, an evaluation cycle in which the cells are updated, and the output cycle.
// The sequencer holds one item at a time, so a stall on the output holds off the input.
// Reset is synchronous and active high; it empties the list but leaves the cell
// contents alone, as only entries below the count are ever observed.
`default_nettype none

module unique_id_list_table_unit
  import ulist_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int ID_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] item_id,
  input  wire logic [5:0]  position,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             ok,
  output logic      [31:0] result_value,
  output logic      [6:0]  entry_count
);

  // The count must reach CAPACITY; compares need room for both the count and a position.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  state_t state, state_next;

  // Operation held for the duration of the item.
  op_t               op;
  logic [ID_WIDTH-1:0] id;
  logic [5:0]        pos;
  logic [CNT_W-1:0]  count, count_next;

  logic              ok_next;
  logic [31:0]       result_next;

  cell_ctl_t           ctl   [CAPACITY];
  logic [ID_WIDTH-1:0] value [CAPACITY];
  logic [ID_WIDTH-1:0] tap   [CAPACITY];
  logic [CAPACITY-1:0] match;

  logic [CMP_W-1:0]    cnt_ext, pos_ext;
  logic                any_match, add_do, rem_do;
  logic [CNT_W-1:0]    found_pos;
  logic [ID_WIDTH-1:0] read_value;

  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign cnt_ext  = CMP_W'(count);
  assign pos_ext  = CMP_W'(pos);

  // Sequencer: state register and next-state logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: state_next = S_EVAL;
      S_EVAL:  state_next = S_OUT;
      S_OUT: begin
        out_valid = 1'b1;
        if (out_xfer) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Capture the item on its transfer; only the low ID_WIDTH bits of the identifier count.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op  <= op_t'(operation);
      id  <= ID_WIDTH'(item_id);
      pos <= position;
    end
  end

  // The row of cells. Each cell hands its entry to its left-hand neighbour when a
  // removal closes the gap; the last cell has no right-hand neighbour.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(g);
    localparam logic [CMP_W-1:0] NXT = CMP_W'(g + 1);

    logic [ID_WIDTH-1:0] next_value;

    if (g == CAPACITY - 1) begin : g_last
      assign next_value = value[g];
    end else begin : g_inner
      assign next_value = value[g + 1];
    end

    always_comb begin
      ctl[g].probe     = (state == S_PROBE);
      ctl[g].live      = IDX < cnt_ext;
      ctl[g].sel       = IDX == pos_ext;
      ctl[g].load      = add_do && (IDX == cnt_ext);
      ctl[g].take_next = rem_do && (IDX >= pos_ext) && (NXT < cnt_ext);
    end

    ulist_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl[g]),
      .id        (id),
      .next_value(next_value),
      .value     (value[g]),
      .match     (match[g]),
      .tap       (tap[g])
    );
  end

  // Entries are distinct, so at most one cell matches, and only the cell at the position
  // taps: a plain OR across the row gives the position and the read data.
  always_comb begin
    found_pos  = '0;
    read_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found_pos  = found_pos | (match[i] ? CNT_W'(i + 1) : '0);
      read_value = read_value | tap[i];
    end
  end

  assign any_match = |match;
  assign add_do    = (state == S_EVAL) && (op == OP_ADD) && !any_match &&
                     (count < CNT_W'(CAPACITY));
  assign rem_do    = (state == S_EVAL) && (op == OP_REMOVE) && (pos_ext < cnt_ext);

  // Result and count update, worked out in the evaluation cycle.
  always_comb begin
    ok_next     = 1'b0;
    result_next = '0;
    count_next  = count;
    case (op)
      OP_READ: begin
        if (pos_ext < cnt_ext) begin
          ok_next     = 1'b1;
          result_next = 32'(read_value);
        end
      end
      OP_FIND: begin
        ok_next     = any_match;
        result_next = 32'(found_pos);
      end
      OP_ADD: begin
        if (add_do) begin
          ok_next    = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (rem_do) begin
          ok_next    = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      default: ok_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_EVAL) begin
      count <= count_next;
    end
  end

  // Output register; held while the transfer out is stalled.
  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      ok           <= ok_next;
      result_value <= result_next;
      entry_count  <= 7'(count_next);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ulist_cell.sv -----
`default_nettype none

module ulist_cell
  import ulist_pkg::*;
#(
  parameter int ID_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire cell_ctl_t           ctl,
  input  wire logic [ID_WIDTH-1:0] id,
  input  wire logic [ID_WIDTH-1:0] next_value,
  output logic      [ID_WIDTH-1:0] value,
  output logic                     match,
  output logic      [ID_WIDTH-1:0] tap
);

  // The entry itself: written by an append or by the gap-closing shift.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= id;
    end else if (ctl.take_next) begin
      value <= next_value;
    end
  end

  // Compare and read results, registered so the sequencer sees them in the cycle after the probe.
  always_ff @(posedge clk) begin
    if (ctl.probe) begin
      match <= ctl.live && (value == id);
      tap   <= ctl.sel ? value : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ulist_checker.sv -----
`default_nettype none

module ulist_checker #(
  parameter int CAPACITY = 64
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        ok,
  input wire logic [31:0] result_value,
  input wire logic [6:0]  entry_count
);

  // Every transfer in has its result offered once the probe and evaluation states have passed.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> ##3 out_valid)
    else $error("result not offered three cycles after a transfer in");

  // One item at a time: no transfer in while a result waits.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  // The list never grows beyond its capacity.
  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(entry_count) <= CAPACITY))
    else $error("entry count beyond capacity");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(ok) &&
      $stable(result_value) && $stable(entry_count)))
    else $error("stalled result changed");

endmodule

bind unique_id_list_table_unit ulist_checker #(.CAPACITY(CAPACITY)) u_ulist_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_unique_id_list_table_unit.sv -----
`timescale 1ns / 100ps

module tb_unique_id_list_table_unit;
  import ulist_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int ID_WIDTH    = 32;
  // Well beyond the slowest correct run, even with both sides idling heavily.
  localparam int CYCLE_LIMIT = 300000;
  // Cycles to wait after the last result, so that a stray extra result is caught.
  localparam int TAIL_CYCLES = 16;

  // One expected result: the three output fields of a transfer out.
  typedef struct packed {
    logic        ok;
    logic [31:0] value;
    logic [6:0]  count;
  } list_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_READ;
  logic [31:0] item_id = '0;
  logic [5:0]  position = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        ok;
  logic [31:0] result_value;
  logic [6:0]  entry_count;

  // Our own copy of the list, kept in order, and the results still to come.
  logic [31:0] id_list[$];
  list_reply_t pending_replies[$];

  // Percentage of cycles in which the sender holds back or the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int error_count = 0;
  int cycle_count = 0;

  unique_id_list_table_unit #(
    .CAPACITY (CAPACITY),
    .ID_WIDTH (ID_WIDTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .item_id      (item_id),
    .position     (position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .result_value (result_value),
    .entry_count  (entry_count)
  );

  // A 4 ns clock: two nanoseconds low, then two high.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog. If the run hangs, for instance because the block never lowers its
  // stall or never offers a result, it is ended here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiving side stalls at random. It changes only at the falling edge, so
  // the block sees a settled value at each rising edge.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // Works out what one accepted operation must return, and updates our copy of
  // the list in the same way the block is meant to update its own.
  function automatic list_reply_t apply_list_op(op_t op, logic [31:0] id,
                                                logic [5:0] pos);
    list_reply_t reply;
    int          hit;
    reply = '0;
    hit = -1;
    // The first match decides the position reported by a find, and any match
    // at all turns an add away as a duplicate.
    foreach (id_list[i]) begin
      if (hit < 0 && id_list[i] == id) hit = i;
    end
    case (op)
      OP_READ: begin
        if (pos < id_list.size()) begin
          reply.ok = 1'b1;
          reply.value = id_list[pos];
        end
      end
      OP_FIND: begin
        if (hit >= 0) begin
          reply.ok = 1'b1;
          reply.value = hit + 1;
        end
      end
      OP_ADD: begin
        if (hit < 0 && id_list.size() < CAPACITY) begin
          id_list.push_back(id);
          reply.ok = 1'b1;
        end
      end
      default: begin
        // Removing closes the gap, so later entries move down by one place.
        if (pos < id_list.size()) begin
          id_list.delete(pos);
          reply.ok = 1'b1;
        end
      end
    endcase
    reply.count = 7'(id_list.size());
    return reply;
  endfunction

  task automatic report_error(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // Result checker. Every transfer out is compared with the oldest expectation;
  // a transfer out with nothing expected is an error in its own right.
  always @(posedge clk) begin
    list_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t ns: result with no expectation waiting (ok %0d, value %h, count %0d)",
                   $time, ok, result_value, entry_count);
      end else begin
        want = pending_replies.pop_front();
        if (ok !== want.ok) report_error("ok", 32'(want.ok), 32'(ok));
        if (result_value !== want.value) report_error("result_value", want.value, result_value);
        if (entry_count !== want.count)
          report_error("entry_count", 32'(want.count), 32'(entry_count));
      end
    end
  end

  // Sends one item. The sender may first hold back for a random number of cycles;
  // then the payload is held until the rising edge at which the transfer happens.
  // Valid is left high afterwards, so that back-to-back items never see it
  // lowered and raised within one time step.
  task automatic send_item(input op_t op, input logic [31:0] id, input logic [5:0] pos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    operation = op;
    item_id = id;
    position = pos;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(apply_list_op(op, id, pos));
  endtask

  // Holds the sender back until every expected result has been seen.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Operations on an empty list: every read and remove is out of range, and a
  // find cannot match.
  task automatic test_empty_list();
    send_item(OP_READ, 32'h0, 6'd0);
    send_item(OP_READ, 32'h0, 6'd63);
    send_item(OP_FIND, 32'h0, 6'd0);
    send_item(OP_REMOVE, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_REMOVE, 32'h0, 6'd63);
  endtask

  // Directed walk through all four operations with the extreme identifiers,
  // including a duplicate add, a failed find, and reads and removes just past
  // the end of the list.
  task automatic test_add_find_remove();
    send_item(OP_ADD, 32'h0000_0000, 6'd0);
    send_item(OP_ADD, 32'hFFFF_FFFF, 6'd63);
    send_item(OP_ADD, 32'h8000_0001, 6'd0);
    send_item(OP_ADD, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_FIND, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_FIND, 32'h0000_0000, 6'd63);
    send_item(OP_FIND, 32'h5A5A_A5A5, 6'd0);
    send_item(OP_READ, 32'h0, 6'd1);
    send_item(OP_READ, 32'h0, 6'd2);
    send_item(OP_READ, 32'h0, 6'd3);
    send_item(OP_REMOVE, 32'h0, 6'd3);
    send_item(OP_REMOVE, 32'h0, 6'd0);
    send_item(OP_READ, 32'h0, 6'd0);
    send_item(OP_FIND, 32'h8000_0001, 6'd0);
    send_item(OP_REMOVE, 32'h0, 6'd1);
    send_item(OP_FIND, 32'h8000_0001, 6'd0);
  endtask

  // Fills the list to capacity with random identifiers, then exercises the full
  // list: an add of a new identifier must be turned away, as must a duplicate,
  // and the last position must be readable and removable.
  task automatic test_full_list();
    logic [31:0] fresh;
    while (id_list.size() < CAPACITY)
      send_item(OP_ADD, $urandom, 6'($urandom_range(63)));
    fresh = ~id_list[0];
    send_item(OP_ADD, fresh, 6'd0);
    send_item(OP_ADD, id_list[CAPACITY-1], 6'd0);
    send_item(OP_READ, 32'h0, 6'd63);
    send_item(OP_FIND, id_list[CAPACITY-1], 6'd0);
    send_item(OP_REMOVE, 32'h0, 6'd63);
    send_item(OP_ADD, fresh, 6'd0);
    send_item(OP_REMOVE, 32'h0, 6'd0);
    send_item(OP_FIND, fresh, 6'd0);
  endtask

  // Random operations. The list is steered towards a target length that is
  // redrawn now and then, so that it wanders between empty and full. Finds,
  // reads and removes mostly refer to entries that exist, and a share of the
  // adds repeat an existing identifier.
  task automatic test_random_mix(input int n_items);
    op_t         op;
    logic [31:0] id;
    logic [5:0]  pos;
    int          target;
    int          sz;
    int          roll;
    target = $urandom_range(CAPACITY);
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 39) target = $urandom_range(CAPACITY);
      sz = id_list.size();
      roll = $urandom_range(99);
      if (roll < 20) op = OP_READ;
      else if (roll < 40) op = OP_FIND;
      else if (roll < ((sz < target) ? 85 : 55)) op = OP_ADD;
      else op = OP_REMOVE;

      if (sz > 0 && $urandom_range(9) < ((op == OP_ADD) ? 2 : 6)) begin
        id = id_list[$urandom_range(sz - 1)];
      end else if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: id = 32'h0000_0000;
          1: id = 32'hFFFF_FFFF;
          2: id = 32'h0000_0001;
          default: id = 32'h8000_0000;
        endcase
      end else begin
        id = $urandom;
      end

      if (sz > 0 && $urandom_range(9) < 7) pos = 6'($urandom_range(sz - 1));
      else pos = 6'($urandom_range(63));

      send_item(op, id, pos);
    end
  endtask

  initial begin
    // Reset is held and then released at a falling edge.
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed part with neither side idling.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_empty_list();
    test_add_find_remove();
    wait_for_drain();

    // Sender holds back often.
    send_idle_pct = 53;
    recv_stall_pct = 0;
    test_random_mix(220);
    wait_for_drain();

    // Receiver stalls often, which also holds off the input side.
    send_idle_pct = 0;
    recv_stall_pct = 53;
    test_random_mix(220);
    wait_for_drain();

    // Both sides idle; the full list is visited here.
    send_idle_pct = 30;
    recv_stall_pct = 30;
    test_full_list();
    test_random_mix(220);

    // A closing stretch at full rate.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_mix(120);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
